FILE: src/qsps_pkg.sv
// Shared types, character codes and the hex/percent decode helpers of the query splitter.
package qsps_pkg;

  localparam int unsigned RES_SLOTS = 3;

  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] SEP_RESET = 8'h26;  // '&'

  typedef enum logic [1:0] {
    PH_BETWEEN,
    PH_LEAD,
    PH_NAME,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT,
    ESC_DIGIT
  } esc_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_END_NOVAL,
    KIND_END_VAL,
    KIND_QUERY_END
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        in_value;
    logic [6:0]  idx;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    esc_t       esc;
    logic [3:0] hn;
  } dec_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = b - CH_ZERO;
      h = '{ok: 1'b1, val: d[3:0]};
    end else if (b >= CH_LC_A && b <= CH_LC_F) begin
      d = b - CH_LC_A + 8'd10;
      h = '{ok: 1'b1, val: d[3:0]};
    end else if (b >= CH_UC_A && b <= CH_UC_F) begin
      d = b - CH_UC_A + 8'd10;
      h = '{ok: 1'b1, val: d[3:0]};
    end
    return h;
  endfunction

  // One byte of field text through the percent decoder. A bad digit drops the
  // pending escape and lets the byte fall through as an ordinary one.
  function automatic dec_t decode(input logic [7:0] b, input esc_t esc,
                                  input logic [3:0] hn);
    dec_t r;
    hex_t h;
    logic plain;
    h = hex_value(b);
    r = '{emit: 1'b0, data: 8'h00, esc: ESC_NONE, hn: hn};
    plain = 1'b1;
    if (esc == ESC_PCT) begin
      if (h.ok) begin
        r.hn  = h.val;
        r.esc = ESC_DIGIT;
        plain = 1'b0;
      end
    end else if (esc == ESC_DIGIT) begin
      if (h.ok) begin
        r.emit = 1'b1;
        r.data = {hn, h.val};
        plain  = 1'b0;
      end
    end
    if (plain) begin
      if (b == CH_PCT) begin
        r.esc = ESC_PCT;
      end else if (b == CH_PLUS) begin
        r.emit = 1'b1;
        r.data = CH_SPACE;
      end else begin
        r.emit = 1'b1;
        r.data = b;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/query_string_pair_splitter.sv
// Query-string splitter: splits raw bytes into name/value pairs and percent-decodes them.
//
// Usage. Raw query bytes enter on the in_ channel (in_valid / in_stall), with in_last
// marking the final byte of a query. Results leave on the out_ channel (out_valid /
// out_stall): decoded data bytes, pair-end markers with or without a value, and a
// query-end marker. Each input item gives zero to three results; out_run_last flags the
// final result of an item. The separator byte is written through cfg_valid / cfg_ready /
// cfg_pair_separator while the block is idle; the user must ensure it (not enforced).
//
// An accepted item waits in the input register, then the decode logic loads a
// small result bundle. Items that give at most one result flow at one item per
// cycle while the receiver does not stall; an item with more results holds the
// bundle until all have left, since the output port shows one result a cycle.
// The input register lets one more item be taken while the bundle still waits.
//
// Synchronous active-low reset clears the parse state, empties both stages and
// sets the separator back to '&'. When the receiver stalls, the shown result is
// held, the bundle is frozen, and in_stall rises once the input register is full.
module query_string_pair_splitter
  import qsps_pkg::*;
#(
  parameter int unsigned MAX_PAIRS = 128
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_in_value,
  output logic [6:0] out_pair_index,
  output logic       out_run_last,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_pair_separator
);

  // The count reaches MAX_PAIRS at most, since a pair only opens below it.
  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);

  logic [7:0]    sep_r;

  // Input register.
  logic          s1_vld_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;

  // Parse state.
  phase_t        phase_r, phase_nxt;
  esc_t          esc_r, esc_nxt;
  logic [3:0]    hn_r, hn_nxt;
  logic [CW-1:0] pc_r, pc_nxt;

  // Result bundle: slot 0 is what the output port shows.
  result_t       res_r [RES_SLOTS];
  result_t       res_nxt [RES_SLOTS];
  logic [1:0]    cnt_r;
  logic [1:0]    n_nxt;

  logic          out_fire;
  logic          bundle_free;
  logic          s1_take;

  // Decisions shared by next-state and result logic.
  phase_t        ph_start, ph_lead, ph_mid;
  esc_t          esc_start;
  logic [3:0]    hn_start;
  logic          opening;
  logic          in_name, in_val;
  logic          is_sep, is_eq;
  logic          byte_close, goto_val, do_dec, data_emit, last_close;
  kind_t         byte_kind, last_kind;
  dec_t          dec;
  logic [CW-1:0] pc_mid;

  assign cfg_ready = 1'b1;

  assign out_fire    = (cnt_r != 2'd0) && !out_stall;
  assign bundle_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall);
  assign s1_take     = s1_vld_r && bundle_free;
  assign in_stall    = s1_vld_r && !bundle_free;

  // A new pair opens only below the pair limit; past it the rest of the query gives only its query-end marker.
  assign opening   = (phase_r == PH_BETWEEN) && (pc_r < CW'(MAX_PAIRS));
  assign ph_start  = opening ? PH_LEAD : phase_r;
  assign esc_start = opening ? ESC_NONE : esc_r;
  assign hn_start  = opening ? 4'h0 : hn_r;
  assign ph_lead   = ((ph_start == PH_LEAD) && (s1_byte_r != CH_SPACE)) ? PH_NAME : ph_start;

  assign in_name = (ph_lead == PH_NAME);
  assign in_val  = (ph_lead == PH_VALUE);
  assign is_sep  = (s1_byte_r == sep_r);
  assign is_eq   = (s1_byte_r == CH_EQ);

  // In a name '=' wins over the separator; in a value only the separator counts.
  assign goto_val   = in_name && is_eq;
  assign byte_close = (in_name && !is_eq && is_sep) || (in_val && is_sep);
  assign do_dec     = (in_name && !is_eq && !is_sep) || (in_val && !is_sep);
  assign byte_kind  = in_val ? KIND_END_VAL : KIND_END_NOVAL;

  assign dec       = decode(s1_byte_r, esc_start, hn_start);
  assign data_emit = do_dec && dec.emit;

  always_comb begin
    if (byte_close) begin
      ph_mid = PH_BETWEEN;
    end else if (goto_val) begin
      ph_mid = PH_VALUE;
    end else begin
      ph_mid = ph_lead;
    end
  end

  // A pair still open at the end of the query is closed before the query end.
  assign last_close = s1_last_r && (ph_mid != PH_BETWEEN);
  assign last_kind  = (ph_mid == PH_VALUE) ? KIND_END_VAL : KIND_END_NOVAL;
  assign pc_mid     = pc_r + CW'(byte_close);

  // Next parse state.
  always_comb begin
    if (s1_last_r) begin
      phase_nxt = PH_BETWEEN;
      esc_nxt   = ESC_NONE;
      hn_nxt    = 4'h0;
      pc_nxt    = '0;
    end else begin
      phase_nxt = ph_mid;
      pc_nxt    = pc_mid;
      if (byte_close || goto_val) begin
        esc_nxt = ESC_NONE;
        hn_nxt  = 4'h0;
      end else if (do_dec) begin
        esc_nxt = dec.esc;
        hn_nxt  = dec.hn;
      end else begin
        esc_nxt = esc_start;
        hn_nxt  = hn_start;
      end
    end
  end

  // Results of this item, in order: data byte, pair end, query end.
  always_comb begin : build_results
    logic [1:0] n_v;
    n_v = 2'd0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      res_nxt[i] = '0;
    end
    if (data_emit) begin
      res_nxt[n_v] = '{kind: KIND_DATA, data: dec.data, in_value: in_val, idx: 7'(pc_r)};
      n_v = n_v + 2'd1;
    end
    if (byte_close) begin
      res_nxt[n_v] = '{kind: byte_kind, data: 8'h00, in_value: 1'b0, idx: 7'(pc_r)};
      n_v = n_v + 2'd1;
    end
    if (last_close) begin
      res_nxt[n_v] = '{kind: last_kind, data: 8'h00, in_value: 1'b0, idx: 7'(pc_mid)};
      n_v = n_v + 2'd1;
    end
    if (s1_last_r) begin
      res_nxt[n_v] = '{kind: KIND_QUERY_END, data: 8'h00, in_value: 1'b0,
                       idx: 7'(pc_mid + CW'(last_close))};
      n_v = n_v + 2'd1;
    end
    n_nxt = n_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sep_r <= cfg_pair_separator;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_vld_r <= 1'b1;
    end else if (s1_take) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BETWEEN;
      esc_r   <= ESC_NONE;
      hn_r    <= 4'h0;
      pc_r    <= '0;
    end else if (s1_take) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      hn_r    <= hn_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (s1_take) begin
      cnt_r <= n_nxt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Slots shift toward slot 0 as results leave.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      for (int i = 0; i < RES_SLOTS; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < RES_SLOTS - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_kind       = res_r[0].kind;
  assign out_byte       = res_r[0].data;
  assign out_in_value   = res_r[0].in_value;
  assign out_pair_index = res_r[0].idx;
  assign out_run_last   = (cnt_r == 2'd1);

endmodule

FILE: src/qsps_checker.sv
// Port-level checker for the query splitter and its bind to the top level.
module qsps_checker
  import qsps_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_in_value,
  input logic [6:0] out_pair_index,
  input logic       out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_pair_index) && $stable(out_run_last))
    else $error("stalled result changed");

  a_qend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_QUERY_END) |-> out_run_last)
    else $error("query end is not the final result of its item");

  a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> (out_byte == 8'h00) && !out_in_value)
    else $error("marker carries data");

  a_qend_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_QUERY_END) |=>
      !out_valid || (out_pair_index == 7'd0))
    else $error("next query does not start at pair zero");

endmodule

bind query_string_pair_splitter qsps_checker u_qsps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_byte       (out_byte),
  .out_in_value   (out_in_value),
  .out_pair_index (out_pair_index),
  .out_run_last   (out_run_last)
);
